// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the bit-bang master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/i2cbb_pkg.sv
// Shared types, constants and sequencing functions for the bit-bang master.
package i2cbb_pkg;

   localparam int UNIT_W      = 10;
   localparam int STEP_W      = 6;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_SEND  = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WACK  = 3'd5
   } cmd_type;

   // One queued word: decoded command plus the fields of its tick.
   typedef struct packed {
      cmd_type             cmd;
      logic [BYTE_W-1:0]   tx_byte;
      logic                send_ack;
      logic                sda_in;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Line levels and the data registers that boundaries touch.
   typedef struct packed {
      logic                scl;
      logic                sda;
      logic [BYTE_W-1:0]   shift;
      logic [BYTE_W-1:0]   rd;
      logic                ack;
   } line_type;

   function automatic logic [STEP_W-1:0] cmd_units(cmd_type c);
      logic [STEP_W-1:0] u;
      case (c)
         CMD_START: u = STEP_W'(3);
         CMD_STOP:  u = STEP_W'(3);
         CMD_SEND:  u = STEP_W'(32);
         CMD_READ:  u = STEP_W'(37);
         CMD_WACK:  u = STEP_W'(3);
         default:   u = '0;
      endcase
      return u;
   endfunction

   // Apply the actions of boundary k of command c.
   function automatic line_type boundary(line_type s, cmd_type c, logic [STEP_W-1:0] k,
                                         logic sda_in, logic ack_choice);
      line_type          n;
      logic [STEP_W-1:0] km1;
      n   = s;
      km1 = k - STEP_W'(1);
      case (c)
         CMD_START: begin
            if (k == STEP_W'(0)) begin
               n.sda = 1'b1;
               n.scl = 1'b1;
            end else if (k == STEP_W'(1)) begin
               n.sda = 1'b0;
            end else if (k == STEP_W'(2)) begin
               n.scl = 1'b0;
            end
         end
         CMD_STOP: begin
            if (k == STEP_W'(0)) n.sda = 1'b0;
            else if (k == STEP_W'(1)) n.scl = 1'b1;
            else if (k == STEP_W'(2)) n.sda = 1'b1;
         end
         CMD_SEND: begin
            if (k < STEP_W'(32)) begin
               case (k[1:0])
                  2'd0: begin
                     n.sda   = s.shift[BYTE_W-1];
                     n.shift = {s.shift[BYTE_W-2:0], 1'b0};
                  end
                  2'd1:    n.scl = 1'b1;
                  2'd3:    n.scl = 1'b0;
                  default: n.scl = s.scl;
               endcase
            end
         end
         CMD_READ: begin
            if (k == STEP_W'(0)) begin
               n.sda = 1'b1;
            end else if (k < STEP_W'(33)) begin
               case (km1[1:0])
                  2'd0:    n.scl = 1'b0;
                  2'd2:    n.scl = 1'b1;
                  2'd3:    n.shift = {s.shift[BYTE_W-2:0], sda_in};
                  default: n.scl = s.scl;
               endcase
            end else if (k == STEP_W'(33)) begin
               n.scl = 1'b0;
               n.sda = ~ack_choice;
            end else if (k == STEP_W'(34)) begin
               n.scl = 1'b1;
            end else if (k == STEP_W'(36)) begin
               n.scl = 1'b0;
            end else if (k == STEP_W'(37)) begin
               n.sda = 1'b1;
               n.rd  = s.shift;
            end
         end
         CMD_WACK: begin
            if (k == STEP_W'(0)) begin
               n.sda = 1'b1;
            end else if (k == STEP_W'(1)) begin
               n.scl = 1'b1;
            end else if (k == STEP_W'(2)) begin
               n.ack = ~sda_in;
               n.scl = 1'b0;
            end
         end
         default: n = s;
      endcase
      return n;
   endfunction

endpackage

// File: hdl/i2cbb_front.sv
// Front end: accepts request words and decodes the command code.
module i2cbb_front import i2cbb_pkg::*; (
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic [BYTE_W-1:0] req_tx_byte,
   input  logic              req_send_ack,
   input  logic              req_sda_in,
   input  q_stat_type        q_stat,
   output logic              push,
   output word_type          push_word
);

   cmd_type cmd;

   // Unused codes act as no command.
   always_comb begin
      if (req_type inside {[CMD_START:CMD_WACK]}) cmd = cmd_type'(req_type);
      else cmd = CMD_NONE;
   end

   assign req_ready = ~q_stat.full & ~reset;
   assign push      = req_valid & req_ready;

   always_comb begin
      push_word.cmd      = cmd;
      push_word.tx_byte  = req_tx_byte;
      push_word.send_ack = req_send_ack;
      push_word.sda_in   = req_sda_in;
   end

endmodule

// File: hdl/i2cbb_queue.sv
// Short word queue between the front end and the sequencer.
module i2cbb_queue import i2cbb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  word_type   push_word,
   input  logic       pop,
   output word_type   pop_word,
   output q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push & ~q_stat.full;
   assign do_pop       = pop & ~q_stat.empty;
   assign pop_word     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_word;
   end

endmodule

// File: hdl/i2cbb_back.sv
// Back end: tick sequencer for the bus commands and the result register.
module i2cbb_back import i2cbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [UNIT_W-1:0] csr_wr_data,
   input  q_stat_type        q_stat,
   input  word_type          pop_word,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl_out,
   output logic              rsp_sda_out,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [BYTE_W-1:0] rsp_rx_byte,
   output logic              rsp_ack_seen,
   output logic              rsp_cmd_rejected
);

   logic [UNIT_W-1:0] unit_ff;
   line_type          line_ff, line_in, seed;
   cmd_type           active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in, step_nx;
   logic [UNIT_W-1:0] tick_ff, tick_in, tick_nx, unit_len;
   logic              choice_ff, choice_in;
   logic              done, rej;
   logic              valid_ff, valid_in;
   logic              scl_ff, sda_ff, busy_ff, done_ff, ack_ff, rej_ff;
   logic [BYTE_W-1:0] rx_ff;

   // Take the next word whenever the result register is free or draining.
   assign pop       = ~q_stat.empty & (~valid_ff | rsp_ready);
   assign unit_len  = (unit_ff == '0) ? UNIT_W'(1) : unit_ff;
   assign tick_nx   = tick_ff + UNIT_W'(1);
   assign step_nx   = step_ff + STEP_W'(1);

   always_comb begin
      line_in   = line_ff;
      active_in = active_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      choice_in = choice_ff;
      done      = 1'b0;
      rej       = 1'b0;
      seed      = line_ff;
      if (pop) begin
         if (active_ff != CMD_NONE) begin
            tick_in = tick_nx;
            if (tick_nx >= unit_len) begin
               tick_in = '0;
               step_in = step_nx;
               line_in = boundary(line_ff, active_ff, step_nx, pop_word.sda_in, choice_ff);
               if (step_nx >= cmd_units(active_ff)) begin
                  active_in = CMD_NONE;
                  step_in   = '0;
                  done      = 1'b1;
               end
            end
         end
         if (pop_word.cmd != CMD_NONE) begin
            if (active_in != CMD_NONE) begin
               rej = 1'b1;
            end else begin
               active_in  = pop_word.cmd;
               step_in    = '0;
               tick_in    = '0;
               choice_in  = pop_word.send_ack;
               seed       = line_in;
               seed.shift = (pop_word.cmd == CMD_SEND) ? pop_word.tx_byte : '0;
               line_in    = boundary(seed, pop_word.cmd, '0, pop_word.sda_in,
                                     pop_word.send_ack);
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= UNIT_W'(1);
         line_ff   <= '{scl: 1'b1, sda: 1'b1, shift: '0, rd: '0, ack: 1'b0};
         active_ff <= CMD_NONE;
         step_ff   <= '0;
         tick_ff   <= '0;
         choice_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) unit_ff <= csr_wr_data;
         line_ff   <= line_in;
         active_ff <= active_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         choice_ff <= choice_in;
         valid_ff  <= valid_in;
      end
   end

   // Hold the result word until it is taken.
   always_ff @(posedge clock) begin
      if (pop) begin
         scl_ff  <= line_in.scl;
         sda_ff  <= line_in.sda;
         busy_ff <= (active_in != CMD_NONE);
         done_ff <= done;
         rx_ff   <= line_in.rd;
         ack_ff  <= line_in.ack;
         rej_ff  <= rej;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_scl_out      = scl_ff;
   assign rsp_sda_out      = sda_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_rx_byte      = rx_ff;
   assign rsp_ack_seen     = ack_ff;
   assign rsp_cmd_rejected = rej_ff;

endmodule

// File: hdl/i2c_bitbang_master.sv
// Tick-driven I2C bit-bang master: each request word is one tick and yields one response
// word with the SCL/SDA levels after that tick. Sustained rate is one word per cycle while
// rsp_ready holds high; a taken word passes through the request queue and then the
// sequencer's result register to the response port. Start, stop and wait-ack take 3 delay
// units, send byte 32 and read byte 37, each unit being csr unit_ticks request words long. A
// command that arrives while another is running is dropped and flagged in rsp_cmd_rejected.
module i2c_bitbang_master import i2cbb_pkg::*; #(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [UNIT_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic [BYTE_W-1:0] req_tx_byte,
   input  logic              req_send_ack,
   input  logic              req_sda_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl_out,
   output logic              rsp_sda_out,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [BYTE_W-1:0] rsp_rx_byte,
   output logic              rsp_ack_seen,
   output logic              rsp_cmd_rejected
);

`include "assert_macros.svh"

   q_stat_type q_stat;
   logic       push, pop;
   word_type   push_word, pop_word;

   i2cbb_front u_front (
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_tx_byte  (req_tx_byte),
      .req_send_ack (req_send_ack),
      .req_sda_in   (req_sda_in),
      .q_stat       (q_stat),
      .push         (push),
      .push_word    (push_word)
   );

   i2cbb_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .q_stat    (q_stat)
   );

   i2cbb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .q_stat           (q_stat),
      .pop_word         (pop_word),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_ack_seen     (rsp_ack_seen),
      .rsp_cmd_rejected (rsp_cmd_rejected)
   );

   `CHK_SAME(a_q_stat, clock, reset, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
   `CHK_NEXT(a_pop_out, clock, reset, pop, rsp_valid, "popped word did not reach response")
   `CHK_SAME(a_rej_busy, clock, reset, rsp_valid && rsp_cmd_rejected, rsp_busy_res, "reject idle")

endmodule
